FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FGEO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fgeo checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FGEO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fgeo checker: next-cycle property failed");

`endif

FILE: hdl/fgeo_pkg.sv
// ----------------------------------------------------------------------------
// fgeo_pkg
// Widths, microcode format and control program of the frame geometry block.
// ----------------------------------------------------------------------------
package fgeo_pkg;

	localparam int DIM_BITS      = 15;
	localparam int HALF_BITS     = DIM_BITS - 1;
	localparam int PROD_BITS     = 2 * HALF_BITS;
	localparam int VAL_BITS      = PROD_BITS + 1;
	localparam int DIVC_BITS     = $clog2(VAL_BITS);
	localparam int NEWTON_LIMIT  = 64;
	localparam int STEP_BITS     = $clog2(NEWTON_LIMIT + 1);
	localparam int RADIUS_MARGIN = 4;
	localparam int PC_BITS       = 4;

	typedef logic [PC_BITS-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQ_W,
		OP_SQ_H,
		OP_SUM,
		OP_INIT,
		OP_SETX,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_UPDATE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_ZERO,
		C_STOP,
		C_DIV_BUSY,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	localparam pc_t P_IDLE      = pc_t'(0);
	localparam pc_t P_SQ_W      = pc_t'(1);
	localparam pc_t P_SQ_H      = pc_t'(2);
	localparam pc_t P_SUM       = pc_t'(3);
	localparam pc_t P_INIT      = pc_t'(4);
	localparam pc_t P_TEST      = pc_t'(5);
	localparam pc_t P_SETX      = pc_t'(6);
	localparam pc_t P_DIV_START = pc_t'(7);
	localparam pc_t P_DIV_STEP  = pc_t'(8);
	localparam pc_t P_UPDATE    = pc_t'(9);
	localparam pc_t P_EMIT      = pc_t'(10);

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			P_IDLE:      w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: P_IDLE};
			P_SQ_W:      w = '{op: OP_SQ_W,      cond: C_NEXT,     target: P_IDLE};
			P_SQ_H:      w = '{op: OP_SQ_H,      cond: C_NEXT,     target: P_IDLE};
			P_SUM:       w = '{op: OP_SUM,       cond: C_NEXT,     target: P_IDLE};
			P_INIT:      w = '{op: OP_INIT,      cond: C_ZERO,     target: P_EMIT};
			P_TEST:      w = '{op: OP_NOP,       cond: C_STOP,     target: P_EMIT};
			P_SETX:      w = '{op: OP_SETX,      cond: C_NEXT,     target: P_IDLE};
			P_DIV_START: w = '{op: OP_DIV_START, cond: C_NEXT,     target: P_IDLE};
			P_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY, target: P_DIV_STEP};
			P_UPDATE:    w = '{op: OP_UPDATE,    cond: C_ALWAYS,   target: P_TEST};
			P_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: P_EMIT};
			default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: P_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/fgeo_ifs.sv
// ----------------------------------------------------------------------------
// fgeo_ifs
// Valid/ready channels for frame dimensions and frame geometry results.
// ----------------------------------------------------------------------------
interface fgeo_dims_if import fgeo_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] frame_width;
	logic [DIM_BITS-1:0] frame_height;

	modport source (output valid, output frame_width, output frame_height, input ready);
	modport sink (input valid, input frame_width, input frame_height, output ready);
endinterface

interface fgeo_geom_if import fgeo_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [HALF_BITS-1:0] centre_x;
	logic [HALF_BITS-1:0] centre_y;
	logic [DIM_BITS-1:0]  min_dimension;
	logic [DIM_BITS-1:0]  radius;

	modport source (output valid, output centre_x, output centre_y, output min_dimension,
		output radius, input ready);
	modport sink (input valid, input centre_x, input centre_y, input min_dimension,
		input radius, output ready);
endinterface

FILE: hdl/frame_geometry_with_isqrt_top.sv
// ----------------------------------------------------------------------------
// frame_geometry_with_isqrt_top
// Frame centre, smaller dimension and half-diagonal radius by Newton root.
// ----------------------------------------------------------------------------
// One frame size is taken on dims, one result leaves on geom. The block works
// on one frame at a time, running k Newton iterations per frame, where k is
// capped by NEWTON_LIMIT (roughly 20 at most for full-size frames, none for a
// zero frame). Each iteration steps through test, copy, divider start, then
// the restoring divider that retires one quotient bit per cycle over 29 bits,
// then the update. A small microcode ROM steps the datapath. The next frame is
// taken while the previous result still waits on geom.
module frame_geometry_with_isqrt_top import fgeo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	fgeo_dims_if.sink          dims,
	fgeo_geom_if.source        geom
);

	pc_t                  pc_q;
	pc_t                  pc_next;
	uword_t               uw;
	logic                 take;
	logic                 out_busy;
	logic                 do_load;
	logic                 do_emit;
	logic                 out_vld_q;

	logic [HALF_BITS-1:0] hw_q;
	logic [HALF_BITS-1:0] hh_q;
	logic [DIM_BITS-1:0]  min_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [VAL_BITS-1:0]  val_q;
	logic [VAL_BITS-1:0]  x_q;
	logic [VAL_BITS-1:0]  y_q;
	logic [STEP_BITS-1:0] steps_q;
	logic [VAL_BITS-1:0]  rem_q;
	logic [VAL_BITS-1:0]  quo_q;
	logic [DIVC_BITS-1:0] divc_q;

	logic [HALF_BITS-1:0] cx_q;
	logic [HALF_BITS-1:0] cy_q;
	logic [DIM_BITS-1:0]  mn_q;
	logic [DIM_BITS-1:0]  rad_q;

	logic [HALF_BITS-1:0] mul_a;
	logic [PROD_BITS-1:0] mul_p;
	logic [VAL_BITS:0]    trial;
	logic [VAL_BITS:0]    half_sum;
	logic [VAL_BITS:0]    init_sum;

	assign uw       = ucode(pc_q);
	assign out_busy = out_vld_q && !geom.ready;
	assign do_load  = (uw.op == OP_LOAD) && dims.valid;
	assign do_emit  = (uw.op == OP_EMIT) && !out_busy;

	always_comb begin
		case (uw.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = !dims.valid;
			C_ZERO:     take = (val_q == '0);
			C_STOP:     take = !((y_q < x_q) && (steps_q < STEP_BITS'(NEWTON_LIMIT)));
			C_DIV_BUSY: take = (divc_q != DIVC_BITS'(VAL_BITS - 1));
			C_OUT_BUSY: take = out_busy;
			default:    take = 1'b1;
		endcase
		pc_next = take ? uw.target : pc_q + pc_t'(1);
	end

	assign mul_a    = (uw.op == OP_SQ_W) ? hw_q : hh_q;
	assign mul_p    = PROD_BITS'(mul_a) * PROD_BITS'(mul_a);
	assign trial    = {rem_q, quo_q[VAL_BITS-1]} - {1'b0, x_q};
	assign half_sum = {1'b0, x_q} + {1'b0, quo_q};
	assign init_sum = {1'b0, val_q} + (VAL_BITS+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= P_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (do_emit)
				out_vld_q <= 1'b1;
			else if (geom.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (do_load) begin
					hw_q  <= dims.frame_width[DIM_BITS-1:1];
					hh_q  <= dims.frame_height[DIM_BITS-1:1];
					min_q <= (dims.frame_width < dims.frame_height) ?
						dims.frame_width : dims.frame_height;
				end
			end
			OP_SQ_W: prod_q <= mul_p;
			OP_SQ_H: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_SUM: val_q <= VAL_BITS'(acc_q) + VAL_BITS'(prod_q);
			OP_INIT: begin
				x_q     <= val_q;
				y_q     <= init_sum[VAL_BITS:1];
				steps_q <= '0;
			end
			OP_SETX: begin
				x_q     <= y_q;
				steps_q <= steps_q + STEP_BITS'(1);
			end
			OP_DIV_START: begin
				rem_q  <= '0;
				quo_q  <= val_q;
				divc_q <= '0;
			end
			OP_DIV_STEP: begin
				if (!trial[VAL_BITS]) begin
					rem_q <= trial[VAL_BITS-1:0];
					quo_q <= {quo_q[VAL_BITS-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[VAL_BITS-2:0], quo_q[VAL_BITS-1]};
					quo_q <= {quo_q[VAL_BITS-2:0], 1'b0};
				end
				divc_q <= divc_q + DIVC_BITS'(1);
			end
			OP_UPDATE: y_q <= half_sum[VAL_BITS:1];
			OP_EMIT: begin
				if (do_emit) begin
					cx_q  <= hw_q;
					cy_q  <= hh_q;
					mn_q  <= min_q;
					rad_q <= DIM_BITS'(x_q) + DIM_BITS'(RADIUS_MARGIN);
				end
			end
			default: ;
		endcase
	end

	assign dims.ready         = (uw.op == OP_LOAD);
	assign geom.valid         = out_vld_q;
	assign geom.centre_x      = cx_q;
	assign geom.centre_y      = cy_q;
	assign geom.min_dimension = mn_q;
	assign geom.radius        = rad_q;

endmodule

FILE: hdl/fgeo_checker.sv
// ----------------------------------------------------------------------------
// fgeo_checker
// Port-level properties of the frame geometry block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fgeo_checker import fgeo_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [HALF_BITS-1:0] centre_x,
	input logic [HALF_BITS-1:0] centre_y,
	input logic [DIM_BITS-1:0]  min_dimension,
	input logic [DIM_BITS-1:0]  radius
);

	logic [DIM_BITS+1:0] rad_w;
	logic [DIM_BITS+1:0] lo_bound;
	logic [DIM_BITS+1:0] hi_bound;
	logic [HALF_BITS-1:0] min_half;

	assign rad_w    = (DIM_BITS+2)'(radius);
	assign lo_bound = (DIM_BITS+2)'(((centre_x > centre_y) ? centre_x : centre_y)) +
		(DIM_BITS+2)'(RADIUS_MARGIN);
	assign hi_bound = (DIM_BITS+2)'(centre_x) + (DIM_BITS+2)'(centre_y) +
		(DIM_BITS+2)'(RADIUS_MARGIN);
	assign min_half = (centre_x < centre_y) ? centre_x : centre_y;

	`FGEO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(radius))
	`FGEO_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`FGEO_ASSERT_NOW(a_radius_range, out_valid, (rad_w >= lo_bound) && (rad_w <= hi_bound))
	`FGEO_ASSERT_NOW(a_min_matches_centre, out_valid, min_dimension[DIM_BITS-1:1] == min_half)

endmodule

bind frame_geometry_with_isqrt_top fgeo_checker u_fgeo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (dims.valid),
	.in_ready      (dims.ready),
	.out_valid     (geom.valid),
	.out_ready     (geom.ready),
	.centre_x      (geom.centre_x),
	.centre_y      (geom.centre_y),
	.min_dimension (geom.min_dimension),
	.radius        (geom.radius)
);
